FILE: rtl/pid_controller_antiwindup_assert.svh
// Assertion macros for the PID controller block.
// Depends on clk and rst_n being visible in the scope that expands them.
`ifndef PID_CONTROLLER_ANTIWINDUP_ASSERT_SVH
`define PID_CONTROLLER_ANTIWINDUP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PIDAW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PIDAW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pidaw_pkg.sv
// Shared types, constants and the microcode table of the PID controller.
// No dependencies; used by pidaw_div and pid_controller_antiwindup.
package pidaw_pkg;

  localparam int DATA_W  = 32;
  localparam int E_W     = 17;   // error, signed
  localparam int DE_W    = 18;   // error change, signed
  localparam int EDIV_W  = 14;   // error / 10, signed
  localparam int DIV_W   = 48;   // divider dividend and quotient width
  localparam int SUM_W   = 64;
  localparam int PC_W    = 5;

  // x / 10 == (x * RECIP10) >> RECIP10_SH for any 16-bit unsigned x
  localparam logic [DATA_W-1:0] RECIP10    = 32'd52429;
  localparam int                RECIP10_SH = 19;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] measured;
    logic        [31:0] timestamp;
  } in_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] integral_sum;
  } out_t;

  typedef enum logic [2:0] {
    REG_SETPOINT    = 3'd0,
    REG_GAIN_P      = 3'd1,
    REG_GAIN_I      = 3'd2,
    REG_GAIN_D      = 3'd3,
    REG_WINDUP_LOW  = 3'd4,
    REG_WINDUP_HIGH = 3'd5,
    REG_DRIVE_LIMIT = 3'd6,
    REG_BOOST_MODE  = 3'd7
  } cfg_idx_t;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Multiplier operand selects
  typedef enum logic [2:0] {
    A_E, A_EMAG, A_DE, A_ACC, A_DLO, A_DHI
  } a_sel_t;

  typedef enum logic [2:0] {
    B_GP, B_GI, B_GD, B_TR, B_TEN
  } b_sel_t;

  // Product accumulator operations
  typedef enum logic [1:0] {
    SUM_HOLD, SUM_LOAD, SUM_ADD, SUM_ADD_HI
  } sum_op_t;

  // Datapath register actions
  typedef enum logic [3:0] {
    ACT_NONE, ACT_ERR, ACT_DE, ACT_EDIV, ACT_DIV_START, ACT_ACC_ADD,
    ACT_ACC_CLAMP, ACT_DERIV, ACT_SAT, ACT_COMMIT, ACT_OUT, ACT_CLEAR
  } act_t;

  // Sequencer branch kinds
  typedef enum logic [2:0] {
    JMP_NEXT, JMP_WAIT_IN, JMP_IF_CLEAR, JMP_WAIT_DIV, JMP_WAIT_OUT, JMP_ALWAYS
  } jmp_t;

  typedef struct packed {
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    logic              mul_en;
    sum_op_t           sum_op;
    act_t              act;
    jmp_t              jmp;
    logic [PC_W-1:0]   target;
  } ctl_t;

  // Program addresses
  localparam logic [PC_W-1:0] PC_IDLE     = 5'd0;
  localparam logic [PC_W-1:0] PC_ERR      = 5'd1;
  localparam logic [PC_W-1:0] PC_DE       = 5'd2;
  localparam logic [PC_W-1:0] PC_EDIV     = 5'd3;
  localparam logic [PC_W-1:0] PC_DIV      = 5'd4;
  localparam logic [PC_W-1:0] PC_ACC_ADD  = 5'd5;
  localparam logic [PC_W-1:0] PC_ACC_CLMP = 5'd6;
  localparam logic [PC_W-1:0] PC_MUL_P    = 5'd7;
  localparam logic [PC_W-1:0] PC_MUL_I    = 5'd8;
  localparam logic [PC_W-1:0] PC_ADD_I    = 5'd9;
  localparam logic [PC_W-1:0] PC_DERIV    = 5'd10;
  localparam logic [PC_W-1:0] PC_MUL_DLO  = 5'd11;
  localparam logic [PC_W-1:0] PC_MUL_DHI  = 5'd12;
  localparam logic [PC_W-1:0] PC_ADD_DHI  = 5'd13;
  localparam logic [PC_W-1:0] PC_SAT      = 5'd14;
  localparam logic [PC_W-1:0] PC_COMMIT   = 5'd15;
  localparam logic [PC_W-1:0] PC_OUT      = 5'd16;
  localparam logic [PC_W-1:0] PC_CLEAR    = 5'd17;

  localparam ctl_t CTL_NOP = '{a_sel: A_E, b_sel: B_GP, mul_en: 1'b0, sum_op: SUM_HOLD,
                               act: ACT_NONE, jmp: JMP_NEXT, target: PC_IDLE};

  // Microcode ROM: one control word per program step
  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t c;
    c = CTL_NOP;
    unique case (pc)
      PC_IDLE:     c.jmp = JMP_WAIT_IN;
      PC_ERR: begin
        c.act    = ACT_ERR;
        c.jmp    = JMP_IF_CLEAR;
        c.target = PC_CLEAR;
      end
      PC_DE: begin
        c.act    = ACT_DE;
        c.a_sel  = A_EMAG;
        c.b_sel  = B_TEN;
        c.mul_en = 1'b1;
      end
      PC_EDIV: begin
        c.act    = ACT_EDIV;
        c.a_sel  = A_DE;
        c.b_sel  = B_TR;
        c.mul_en = 1'b1;
      end
      PC_DIV:      c.act = ACT_DIV_START;
      PC_ACC_ADD:  c.act = ACT_ACC_ADD;
      PC_ACC_CLMP: c.act = ACT_ACC_CLAMP;
      PC_MUL_P: begin
        c.a_sel  = A_E;
        c.b_sel  = B_GP;
        c.mul_en = 1'b1;
      end
      PC_MUL_I: begin
        c.a_sel  = A_ACC;
        c.b_sel  = B_GI;
        c.mul_en = 1'b1;
        c.sum_op = SUM_LOAD;
      end
      PC_ADD_I:    c.sum_op = SUM_ADD;
      PC_DERIV: begin
        c.act = ACT_DERIV;
        c.jmp = JMP_WAIT_DIV;
      end
      PC_MUL_DLO: begin
        c.a_sel  = A_DLO;
        c.b_sel  = B_GD;
        c.mul_en = 1'b1;
      end
      PC_MUL_DHI: begin
        c.a_sel  = A_DHI;
        c.b_sel  = B_GD;
        c.mul_en = 1'b1;
        c.sum_op = SUM_ADD;
      end
      PC_ADD_DHI:  c.sum_op = SUM_ADD_HI;
      PC_SAT:      c.act = ACT_SAT;
      PC_COMMIT:   c.act = ACT_COMMIT;
      PC_OUT: begin
        c.act    = ACT_OUT;
        c.jmp    = JMP_WAIT_OUT;
        c.target = PC_IDLE;
      end
      PC_CLEAR: begin
        c.act    = ACT_CLEAR;
        c.jmp    = JMP_ALWAYS;
        c.target = PC_OUT;
      end
      default: begin
        c.jmp    = JMP_ALWAYS;
        c.target = PC_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/pidaw_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pidaw_pkg for widths.
module pidaw_div import pidaw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              busy,
  output logic [DIV_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [DATA_W:0]   shifted;
  logic [DATA_W+1:0] trial;
  logic              borrow;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_r};
    borrow  = trial[DATA_W+1];
  end

  // Load on start, else retire one quotient bit per cycle
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    priority if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = borrow ? shifted[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_nxt  = {quo_r[DIV_W-2:0], ~borrow};
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = (cnt_r != CNT_W'(1));
    end else begin
      // Hold while idle
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/pid_controller_antiwindup.sv
// Top level of the PID controller with integrator clamp.
// Depends on pidaw_pkg, pidaw_div and pid_controller_antiwindup_assert.svh.
//
// One result per input transaction. For a control step, the derivative term
// needs a bit-serial divide of (error change * TICK_RATE) by the elapsed ticks,
// and a microcoded sequencer walks one shared 32x32 multiplier and one 64-bit
// accumulator through the remaining steps around it. A clear transaction skips
// these steps. The next transaction can be accepted in the cycle after a result
// is loaded, even while that result still waits on out_ready. Configuration
// registers are written through cfg_we/cfg_index/cfg_wdata and must only change
// while idle.
`include "pid_controller_antiwindup_assert.svh"

module pid_controller_antiwindup import pidaw_pkg::*; #(
  parameter int unsigned TICK_RATE = 125000000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  // Configuration registers
  logic signed [15:0] setpoint_r, gain_p_r, gain_i_r, gain_d_r;
  logic signed [31:0] windup_low_r, drive_limit_r;
  logic        [30:0] windup_high_r;
  logic               boost_mode_r;

  // Sequencer
  logic [PC_W-1:0] pc_r, pc_nxt;
  ctl_t            ctl;
  logic            in_fire;
  logic            out_load;

  // Controller state
  logic signed [E_W-1:0]    prev_error_r;
  logic        [31:0]       prev_time_r;
  logic signed [31:0]       acc_r;
  logic signed [31:0]       last_drive_r;

  // Working registers
  in_t                      in_r;
  logic signed [E_W-1:0]    e_r;
  logic        [31:0]       dt_r;
  logic signed [DE_W-1:0]   de_r;
  logic signed [EDIV_W-1:0] ediv_r;
  logic signed [32:0]       accsum_r;
  logic                     dneg_r;
  logic signed [DIV_W-1:0]  deriv_r;
  logic signed [SUM_W-1:0]  prod_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [31:0]       dsat_r;
  logic                     out_valid_r;
  out_t                     out_data_r;

  // Datapath helpers
  logic        [E_W-1:0]    emag;
  logic signed [31:0]       mul_a, mul_b;
  logic        [SUM_W-1:0]  prod_mag;
  logic signed [32:0]       addend;
  logic signed [31:0]       acc_sat, acc_clamped;
  logic        [DIV_W-1:0]  quo;
  logic                     div_busy;
  logic                     div_start;
  logic signed [31:0]       dsat_nxt;

  // Configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r    <= '0;
      gain_p_r      <= '0;
      gain_i_r      <= '0;
      gain_d_r      <= '0;
      windup_low_r  <= -32'sd65536;
      windup_high_r <= 31'd65536;
      drive_limit_r <= 32'sd65536;
      boost_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_SETPOINT:    setpoint_r    <= cfg_wdata[15:0];
        REG_GAIN_P:      gain_p_r      <= cfg_wdata[15:0];
        REG_GAIN_I:      gain_i_r      <= cfg_wdata[15:0];
        REG_GAIN_D:      gain_d_r      <= cfg_wdata[15:0];
        REG_WINDUP_LOW:  windup_low_r  <= cfg_wdata;
        REG_WINDUP_HIGH: windup_high_r <= cfg_wdata[30:0];
        REG_DRIVE_LIMIT: drive_limit_r <= cfg_wdata;
        REG_BOOST_MODE:  boost_mode_r  <= cfg_wdata[0];
      endcase
    end
  end

  // Fetch the control word and pick the next step
  always_comb begin
    ctl      = ucode(pc_r);
    in_ready = (ctl.jmp == JMP_WAIT_IN);
    in_fire  = in_valid && in_ready;
    out_load = (ctl.act == ACT_OUT) && (!out_valid_r || out_ready);
    unique case (ctl.jmp)
      JMP_NEXT:     pc_nxt = pc_r + PC_W'(1);
      JMP_WAIT_IN:  pc_nxt = in_fire ? pc_r + PC_W'(1) : pc_r;
      JMP_IF_CLEAR: pc_nxt = (in_r.opcode == OP_CLEAR) ? ctl.target : pc_r + PC_W'(1);
      JMP_WAIT_DIV: pc_nxt = div_busy ? pc_r : pc_r + PC_W'(1);
      JMP_WAIT_OUT: pc_nxt = out_load ? ctl.target : pc_r;
      JMP_ALWAYS:   pc_nxt = ctl.target;
      default:      pc_nxt = PC_IDLE;
    endcase
  end

  // Shared multiplier operands
  always_comb begin
    emag = e_r[E_W-1] ? (~e_r + E_W'(1)) : e_r;
    unique case (ctl.a_sel)
      A_E:     mul_a = {{(32-E_W){e_r[E_W-1]}}, e_r};
      A_EMAG:  mul_a = {{(32-E_W){1'b0}}, emag};
      A_DE:    mul_a = {{(32-DE_W){de_r[DE_W-1]}}, de_r};
      A_ACC:   mul_a = acc_r;
      A_DLO:   mul_a = {8'b0, deriv_r[23:0]};
      A_DHI:   mul_a = {{8{deriv_r[DIV_W-1]}}, deriv_r[DIV_W-1:24]};
      default: mul_a = '0;
    endcase
    unique case (ctl.b_sel)
      B_GP:    mul_b = {{16{gain_p_r[15]}}, gain_p_r};
      B_GI:    mul_b = {{16{gain_i_r[15]}}, gain_i_r};
      B_GD:    mul_b = {{16{gain_d_r[15]}}, gain_d_r};
      B_TR:    mul_b = 32'(TICK_RATE);
      B_TEN:   mul_b = RECIP10;
      default: mul_b = '0;
    endcase
  end

  // Accumulator update: saturate to 32 bits, then apply the low windup clamp and, in boost mode, the high one
  always_comb begin
    prod_mag = prod_r[SUM_W-1] ? (~prod_r + SUM_W'(1)) : prod_r;
    addend   = boost_mode_r ? {{(33-EDIV_W){ediv_r[EDIV_W-1]}}, ediv_r}
                            : {{(33-E_W){e_r[E_W-1]}}, e_r};
    if (accsum_r[32] != accsum_r[31]) begin
      acc_sat = accsum_r[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      acc_sat = accsum_r[31:0];
    end
    priority if (acc_sat < windup_low_r) begin
      acc_clamped = windup_low_r;
    end else if (boost_mode_r && (acc_sat > $signed({1'b0, windup_high_r}))) begin
      acc_clamped = {1'b0, windup_high_r};
    end else begin
      acc_clamped = acc_sat;
    end
  end

  // Floor shift by 8 and saturate to 32 bits
  always_comb begin
    if ((&sum_r[SUM_W-1:39]) || !(|sum_r[SUM_W-1:39])) begin
      dsat_nxt = sum_r[39:8];
    end else begin
      dsat_nxt = sum_r[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  assign div_start = (ctl.act == ACT_DIV_START);

  pidaw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_mag[DIV_W-1:0]),
    .divisor  (dt_r),
    .busy     (div_busy),
    .quotient (quo)
  );

  // Sequencer, controller state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= PC_IDLE;
      prev_error_r <= '0;
      prev_time_r  <= '0;
      acc_r        <= '0;
      last_drive_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      unique case (ctl.act)
        ACT_ACC_CLAMP: acc_r <= acc_clamped;
        ACT_CLEAR:     acc_r <= '0;
        ACT_COMMIT: begin
          last_drive_r <= (dsat_r > drive_limit_r) ? drive_limit_r : dsat_r;
          prev_error_r <= e_r;
          prev_time_r  <= in_r.timestamp;
        end
        default: ;
      endcase
      // Drop the result once taken, reload it from the output step
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
    if (ctl.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    unique case (ctl.sum_op)
      SUM_LOAD:   sum_r <= prod_r;
      SUM_ADD:    sum_r <= sum_r + prod_r;
      SUM_ADD_HI: sum_r <= sum_r + {prod_r[SUM_W-25:0], 24'b0};
      default:    ;
    endcase
    unique case (ctl.act)
      ACT_ERR: begin
        e_r  <= {setpoint_r[15], setpoint_r} - {in_r.measured[15], in_r.measured};
        dt_r <= in_r.timestamp - prev_time_r;
      end
      ACT_DE:   de_r <= {e_r[E_W-1], e_r} - {prev_error_r[E_W-1], prev_error_r};
      ACT_EDIV: begin
        ediv_r <= e_r[E_W-1] ? -$signed({1'b0, prod_r[31:RECIP10_SH]})
                             : $signed({1'b0, prod_r[31:RECIP10_SH]});
      end
      ACT_DIV_START: dneg_r   <= prod_r[SUM_W-1];
      ACT_ACC_ADD:   accsum_r <= {acc_r[31], acc_r} + addend;
      ACT_DERIV: begin
        if (dt_r == '0) begin
          deriv_r <= '0;
        end else begin
          deriv_r <= dneg_r ? -$signed(quo) : $signed(quo);
        end
      end
      ACT_SAT: dsat_r <= dsat_nxt;
      ACT_OUT: begin
        if (out_load) begin
          out_data_r.drive        <= last_drive_r;
          out_data_r.integral_sum <= acc_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An accepted transaction always starts with the error step
  `PIDAW_ASSERT_NXT(a_accept_starts, in_fire, pc_r == PC_ERR, "accept did not start program")
  // A result appears only from the output step
  `PIDAW_ASSERT_NXT(a_out_from_step, (pc_r != PC_OUT) && !out_valid_r, !out_valid_r,
                    "result raised outside output step")
  // The divider is never restarted while a division runs
  `PIDAW_ASSERT_IMP(a_div_idle_start, div_start, !div_busy, "divider restarted while busy")

endmodule
